[src/hcr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcr_pkg
// Shared types and constants of the Harris corner response block.
// ----------------------------------------------------------------------------
package hcr_pkg;

   localparam int PIX_W      = 8;
   localparam int CFG_W      = 14;
   localparam int CFG_IDX_W  = 2;
   localparam int HGT_W      = 11;
   localparam int MAX_HEIGHT = 1024;
   localparam int COORD_W    = 10;
   localparam int RESP_W     = 53;
   localparam int GRAD_W     = 11;
   localparam int SQ1_W      = 20;
   localparam int K_W        = 14;
   localparam int K_SHIFT    = 16;
   localparam int RSP_DATA_W = ((RESP_W + 2 * COORD_W + 7) / 8) * 8;

   localparam logic [3:0] TAP_LAST = 4'd8;

   typedef enum logic [CFG_IDX_W-1:0] {
      CSR_FRAME_WIDTH,
      CSR_FRAME_HEIGHT,
      CSR_WINDOW_RADIUS,
      CSR_SENSITIVITY
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LATCH,
      S_STEP,
      S_FETCH,
      S_GRAD,
      S_ACCUM,
      S_MUL_DET,
      S_MUL_CROSS,
      S_MUL_TRACE,
      S_MUL_K,
      S_FINAL,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

   function automatic logic signed [1:0] tap_dx(input logic [3:0] t);
      logic signed [1:0] d;
      case (t) inside
         4'd0, 4'd3, 4'd6: d = -2'sd1;
         4'd1, 4'd4, 4'd7: d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

   function automatic logic signed [1:0] tap_dy(input logic [3:0] t);
      logic signed [1:0] d;
      case (t) inside
         4'd0, 4'd1, 4'd2: d = -2'sd1;
         4'd3, 4'd4, 4'd5: d = 2'sd0;
         default:          d = 2'sd1;
      endcase
      return d;
   endfunction

endpackage
`default_nettype wire

[src/hcr_line_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcr_line_ram
// Pixel ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module hcr_line_ram #(
   parameter int AW = 14,
   parameter int DW = 8
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem_ff [2**AW];
   logic [DW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[src/hcr_serial_mul.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcr_serial_mul
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hcr_serial_mul #(
   parameter int A_W = 50,
   parameter int B_W = 25,
   parameter int P_W = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [A_W-1:0]         a,
   input  logic [B_W-1:0]         b,
   output hcr_pkg::mul_status_type status,
   output logic [P_W-1:0]         p
);
   import hcr_pkg::*;

   logic           busy_ff;
   logic [P_W-1:0] acc_ff;
   logic [P_W-1:0] a_sh_ff;
   logic [B_W-1:0] b_sh_ff;
   logic           done;

   assign done = busy_ff && (b_sh_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (done) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff  <= '0;
         a_sh_ff <= P_W'(a);
         b_sh_ff <= b;
      end else if (busy_ff && !done) begin
         if (b_sh_ff[0]) begin
            acc_ff <= acc_ff + a_sh_ff;
         end
         a_sh_ff <= a_sh_ff << 1;
         b_sh_ff <= b_sh_ff >> 1;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done;
   assign p = acc_ff;

endmodule
`default_nettype wire

[src/harris_corner_response.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// harris_corner_response
// Streaming Harris corner response over a ring of pixel rows.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An item without a result passes through S_STEP
// (after S_LATCH for the first item of a frame); a border or size-error result
// goes from S_STEP to S_EMIT. An interior result adds a window walk over
// (2r+1)^2 positions (tap reads, S_GRAD and S_ACCUM at each) and four serial
// multiplies before S_EMIT, which waits while the output is stalled.
// Synchronous reset clears control state; the pixel RAM is not cleared.
// ----------------------------------------------------------------------------
module harris_corner_response #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_RADIUS = 3
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [hcr_pkg::PIX_W-1:0]        req_tdata,  // pixel
   input  logic                             req_tuser,  // action
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [hcr_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // response, column, row
   output logic                             rsp_tlast,
   output logic                             rsp_tuser,  // size_error
   input  logic                             csr_we,
   input  logic [hcr_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [hcr_pkg::CFG_W-1:0]        csr_wdata
);
   import hcr_pkg::*;

   localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int RB  = $clog2(2 * MAX_RADIUS + 4);
   localparam int AW  = RB + XW;
   localparam int RW  = $clog2(MAX_RADIUS + 1);
   localparam int OW  = RW + 2;
   localparam int CW  = ((WW > HGT_W) ? WW : HGT_W) + 2;
   localparam int SW  = SQ1_W + $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1));
   localparam int TW  = SW + 1;
   localparam int AMW = 2 * TW;
   localparam int PW  = 2 * TW + K_W;
   localparam int NW  = WW + HGT_W;
   localparam int JW  = NW + 1;

   state_type state_ff, state_in;

   logic [10:0]      cfg_w_ff, cfg_h_ff;
   logic [1:0]       cfg_r_ff;
   logic [K_W-1:0]   cfg_k_ff;

   logic [WW-1:0]    cur_w_ff;
   logic [HGT_W-1:0] cur_h_ff;
   logic [RW-1:0]    cur_r_ff;
   logic [K_W-1:0]   cur_k_ff;
   logic             cur_err_ff;

   logic [WW-1:0]    lat_w;
   logic [HGT_W-1:0] lat_h;
   logic [RW-1:0]    lat_r;
   logic [RW+1:0]    lat_diam;
   logic             lat_err;

   logic             act_ff;
   logic [PIX_W-1:0] pix_ff;
   logic [JW-1:0]    j_ff;
   logic [NW-1:0]    p_ff;
   logic [XW-1:0]    px_ff, wx_ff;
   logic [COORD_W-1:0] py_ff, wy_ff;

   logic signed [OW-1:0] wdx_ff, wdy_ff, r_s;
   logic [3:0]       iss_ff, rd_tap_ff;
   logic             rd_vld_ff, issue;
   logic [PIX_W-1:0] taps_ff [9];

   logic signed [GRAD_W-1:0] gx_ff, gy_ff, gx_c, gy_c;
   logic signed [GRAD_W-1:0] t0, t2, t3, t5, t6, t7, t1, t8;
   logic signed [21:0]       pxx, pxy, pyy;
   logic [SW-1:0]            sxx_ff, syy_ff, sxy_abs;
   logic signed [TW-1:0]     sxy_ff;
   logic [TW-1:0]            trace;

   logic [PW-1:0]    m_det_ff, m_cross_ff, m_k_ff, resp_full;
   logic [AMW-1:0]   m_sq_ff;
   logic             launched_ff, mul_start;
   logic [AMW-1:0]   mul_a;
   logic [TW-1:0]    mul_b;
   logic [PW-1:0]    mul_p;
   mul_status_type   mul_st;

   logic [RESP_W-1:0] res_resp_ff;
   logic [NW-1:0]     n_c;
   logic [JW-1:0]     lag_c;
   logic              j_lt_n, zero_case, res_last, out_load, ram_we, win_last;

   logic signed [1:0]    tdx, tdy;
   logic signed [CW-1:0] cx_s, cy_s, w_s, h_s;
   logic [XW-1:0]        cxc;
   logic [COORD_W-1:0]   cyc;
   logic [AW-1:0]        raddr, waddr;
   logic [PIX_W-1:0]     ram_rdata;

   logic                 rsp_valid_ff;
   logic [RESP_W-1:0]    rsp_resp_ff;
   logic [COORD_W-1:0]   rsp_col_ff, rsp_row_ff;
   logic                 rsp_last_ff, rsp_err_ff;

   // frame geometry from the registers
   always_comb begin
      if (cfg_w_ff == '0) begin
         lat_w = WW'(1);
      end else if (32'(cfg_w_ff) > MAX_WIDTH) begin
         lat_w = WW'(MAX_WIDTH);
      end else begin
         lat_w = WW'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         lat_h = HGT_W'(1);
      end else if (32'(cfg_h_ff) > MAX_HEIGHT) begin
         lat_h = HGT_W'(MAX_HEIGHT);
      end else begin
         lat_h = cfg_h_ff;
      end
      if (cfg_r_ff == '0) begin
         lat_r = RW'(1);
      end else if (32'(cfg_r_ff) > MAX_RADIUS) begin
         lat_r = RW'(MAX_RADIUS);
      end else begin
         lat_r = RW'(cfg_r_ff);
      end
      lat_diam = {lat_r, 1'b1};
      lat_err  = (32'(lat_w) < 32'(lat_diam)) || (32'(lat_h) < 32'(lat_diam));
   end

   assign n_c    = NW'(cur_w_ff) * NW'(cur_h_ff);
   assign lag_c  = JW'({1'b0, cur_r_ff} + 1'b1) * JW'({1'b0, cur_w_ff} + 1'b1);
   assign j_lt_n = j_ff < JW'(n_c);
   assign r_s    = $signed({{(OW-RW){1'b0}}, cur_r_ff});

   assign zero_case = cur_err_ff
                   || (32'(px_ff) < 32'(cur_r_ff))
                   || (32'(px_ff) >= 32'(cur_w_ff) - 32'(cur_r_ff))
                   || (32'(py_ff) < 32'(cur_r_ff))
                   || (32'(py_ff) >= 32'(cur_h_ff) - 32'(cur_r_ff));
   assign res_last = ({1'b0, p_ff} + 1'b1) >= {1'b0, n_c};
   assign win_last = (wdx_ff == r_s) && (wdy_ff == r_s);

   // tap address with replicated borders
   assign tdx  = tap_dx(iss_ff);
   assign tdy  = tap_dy(iss_ff);
   assign w_s  = $signed({{(CW-WW){1'b0}}, cur_w_ff});
   assign h_s  = $signed({{(CW-HGT_W){1'b0}}, cur_h_ff});
   assign cx_s = $signed({{(CW-XW){1'b0}}, px_ff}) + CW'(wdx_ff) + CW'(tdx);
   assign cy_s = $signed({{(CW-COORD_W){1'b0}}, py_ff}) + CW'(wdy_ff) + CW'(tdy);

   always_comb begin
      if (cx_s < 0) begin
         cxc = '0;
      end else if (cx_s >= w_s) begin
         cxc = XW'(cur_w_ff - 1'b1);
      end else begin
         cxc = XW'(cx_s);
      end
      if (cy_s < 0) begin
         cyc = '0;
      end else if (cy_s >= h_s) begin
         cyc = COORD_W'(cur_h_ff - 1'b1);
      end else begin
         cyc = COORD_W'(cy_s);
      end
   end

   assign raddr = {cyc[RB-1:0], cxc};
   assign waddr = {wy_ff[RB-1:0], wx_ff};

   hcr_line_ram #(
      .AW (AW),
      .DW (PIX_W)
   ) u_line_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (waddr),
      .wdata (pix_ff),
      .raddr (raddr),
      .rdata (ram_rdata)
   );

   // gradients and products
   assign t0 = $signed({3'b000, taps_ff[0]});
   assign t1 = $signed({3'b000, taps_ff[1]});
   assign t2 = $signed({3'b000, taps_ff[2]});
   assign t3 = $signed({3'b000, taps_ff[3]});
   assign t5 = $signed({3'b000, taps_ff[5]});
   assign t6 = $signed({3'b000, taps_ff[6]});
   assign t7 = $signed({3'b000, taps_ff[7]});
   assign t8 = $signed({3'b000, taps_ff[8]});
   assign gx_c = (t2 - t0) + ((t5 - t3) <<< 1) + (t8 - t6);
   assign gy_c = (t6 - t0) + ((t7 - t1) <<< 1) + (t8 - t2);
   assign pxx  = gx_ff * gx_ff;
   assign pxy  = gx_ff * gy_ff;
   assign pyy  = gy_ff * gy_ff;

   assign sxy_abs = (sxy_ff < 0) ? SW'(-sxy_ff) : SW'(sxy_ff);
   assign trace   = TW'(sxx_ff) + TW'(syy_ff);

   always_comb begin
      case (state_ff)
         S_MUL_DET: begin
            mul_a = AMW'(sxx_ff);
            mul_b = TW'(syy_ff);
         end
         S_MUL_CROSS: begin
            mul_a = AMW'(sxy_abs);
            mul_b = TW'(sxy_abs);
         end
         S_MUL_TRACE: begin
            mul_a = AMW'(trace);
            mul_b = trace;
         end
         default: begin
            mul_a = m_sq_ff;
            mul_b = TW'(cur_k_ff);
         end
      endcase
   end

   hcr_serial_mul #(
      .A_W (AMW),
      .B_W (TW),
      .P_W (PW)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .status (mul_st),
      .p      (mul_p)
   );

   assign resp_full = m_det_ff - m_cross_ff - (m_k_ff >> K_SHIFT);

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ram_we     = 1'b0;
      issue      = 1'b0;
      mul_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = (j_ff == '0) ? S_LATCH : S_STEP;
            end
         end
         S_LATCH: begin
            state_in = S_STEP;
         end
         S_STEP: begin
            if (j_lt_n && act_ff) begin
               state_in = S_IDLE;
            end else begin
               ram_we = j_lt_n;
               if (j_ff < lag_c) begin
                  state_in = S_IDLE;
               end else if (zero_case) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            issue = (iss_ff <= TAP_LAST);
            if (rd_vld_ff && (rd_tap_ff == TAP_LAST)) begin
               state_in = S_GRAD;
            end
         end
         S_GRAD: begin
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            state_in = win_last ? S_MUL_DET : S_FETCH;
         end
         S_MUL_DET, S_MUL_CROSS, S_MUL_TRACE, S_MUL_K: begin
            mul_start = !launched_ff;
            if (launched_ff && mul_st.done) begin
               unique case (state_ff)
                  S_MUL_DET:   state_in = S_MUL_CROSS;
                  S_MUL_CROSS: state_in = S_MUL_TRACE;
                  S_MUL_TRACE: state_in = S_MUL_K;
                  default:     state_in = S_FINAL;
               endcase
            end
         end
         S_FINAL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff     <= 11'd640;
         cfg_h_ff     <= 11'd480;
         cfg_r_ff     <= 2'd1;
         cfg_k_ff     <= 14'd2621;
         cur_w_ff     <= WW'(1);
         cur_h_ff     <= HGT_W'(1);
         cur_r_ff     <= RW'(1);
         cur_k_ff     <= '0;
         cur_err_ff   <= 1'b0;
         j_ff         <= '0;
         p_ff         <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         wx_ff        <= '0;
         wy_ff        <= '0;
         iss_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rd_tap_ff    <= '0;
         launched_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:   cfg_w_ff <= csr_wdata[10:0];
               CSR_FRAME_HEIGHT:  cfg_h_ff <= csr_wdata[10:0];
               CSR_WINDOW_RADIUS: cfg_r_ff <= csr_wdata[1:0];
               CSR_SENSITIVITY:   cfg_k_ff <= csr_wdata;
               default:           cfg_k_ff <= cfg_k_ff;
            endcase
         end
         if (state_ff == S_LATCH) begin
            cur_w_ff   <= lat_w;
            cur_h_ff   <= lat_h;
            cur_r_ff   <= lat_r;
            cur_k_ff   <= cfg_k_ff;
            cur_err_ff <= lat_err;
         end
         if ((state_ff == S_STEP) && !(j_lt_n && act_ff)) begin
            j_ff <= j_ff + 1'b1;
         end
         if (ram_we) begin
            if (32'(wx_ff) == 32'(cur_w_ff) - 1) begin
               wx_ff <= '0;
               wy_ff <= wy_ff + 1'b1;
            end else begin
               wx_ff <= wx_ff + 1'b1;
            end
         end
         if (state_ff == S_STEP) begin
            iss_ff <= '0;
         end else if (state_ff == S_ACCUM) begin
            iss_ff <= '0;
         end else if (issue) begin
            iss_ff <= iss_ff + 1'b1;
         end
         rd_vld_ff <= issue;
         rd_tap_ff <= iss_ff;
         if (mul_start) begin
            launched_ff <= 1'b1;
         end else if (mul_st.done) begin
            launched_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (res_last) begin
               j_ff  <= '0;
               p_ff  <= '0;
               px_ff <= '0;
               py_ff <= '0;
               wx_ff <= '0;
               wy_ff <= '0;
            end else begin
               p_ff <= p_ff + 1'b1;
               if (32'(px_ff) == 32'(cur_w_ff) - 1) begin
                  px_ff <= '0;
                  py_ff <= py_ff + 1'b1;
               end else begin
                  px_ff <= px_ff + 1'b1;
               end
            end
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         act_ff <= req_tuser;
         pix_ff <= req_tdata;
      end
      if (rd_vld_ff) begin
         taps_ff[rd_tap_ff] <= ram_rdata;
      end
      if (state_ff == S_STEP) begin
         wdx_ff      <= -r_s;
         wdy_ff      <= -r_s;
         sxx_ff      <= '0;
         syy_ff      <= '0;
         sxy_ff      <= '0;
         res_resp_ff <= '0;
      end
      if (state_ff == S_GRAD) begin
         gx_ff <= gx_c;
         gy_ff <= gy_c;
      end
      if (state_ff == S_ACCUM) begin
         sxx_ff <= sxx_ff + SW'(pxx[SQ1_W-1:0]);
         syy_ff <= syy_ff + SW'(pyy[SQ1_W-1:0]);
         sxy_ff <= sxy_ff + TW'(pxy);
         if (wdx_ff == r_s) begin
            wdx_ff <= -r_s;
            wdy_ff <= wdy_ff + 1'b1;
         end else begin
            wdx_ff <= wdx_ff + 1'b1;
         end
      end
      if (launched_ff && mul_st.done) begin
         case (state_ff)
            S_MUL_DET:   m_det_ff   <= mul_p;
            S_MUL_CROSS: m_cross_ff <= mul_p;
            S_MUL_TRACE: m_sq_ff    <= mul_p[AMW-1:0];
            default:     m_k_ff     <= mul_p;
         endcase
      end
      if (state_ff == S_FINAL) begin
         res_resp_ff <= resp_full[RESP_W-1:0];
      end
      if (out_load) begin
         rsp_resp_ff <= res_resp_ff;
         rsp_col_ff  <= COORD_W'(px_ff);
         rsp_row_ff  <= py_ff;
         rsp_last_ff <= res_last;
         rsp_err_ff  <= cur_err_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_row_ff, rsp_col_ff, rsp_resp_ff});
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   a_emit_lag: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (j_ff == JW'(p_ff) + lag_c + 1'b1))
      else $error("result index out of step with item count");

   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      mul_start |-> !mul_st.busy)
      else $error("multiplier started while busy");

   a_rd_src: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == S_FETCH))
      else $error("pixel read outside window walk");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (out_load && res_last) |=> ((j_ff == '0) && (p_ff == '0)))
      else $error("frame counters not cleared after last result");

endmodule
`default_nettype wire
